// File: rtl/ptea_pkg.sv
`default_nettype none
package ptea_pkg;

    localparam int TYPE_COUNT = 8;
    localparam int TYPE_W     = 3;
    localparam int TIME_W     = 32;
    localparam int PORT_DW    = 32;
    localparam int OFF_W      = 3;
    localparam int CNT_W      = 4;
    localparam int PRIO_W     = 2;
    localparam int HOLD_W     = 10;
    localparam int AGE_W      = 13;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_SEL  = 2'd1,
        OP_DISP = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_NONE  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

    // command broadcast to the whole row of cells
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_LOAD,
        CMD_ROT,
        CMD_DEL
    } t_cmd;

    function automatic logic [PRIO_W-1:0] type_prio(input logic [TYPE_W-1:0] kind);
        logic [PRIO_W-1:0] p;
        unique case (kind)
            3'd0, 3'd2:             p = 2'd2;
            3'd1, 3'd3, 3'd4, 3'd7: p = 2'd3;
            default:                p = 2'd1;
        endcase
        return p;
    endfunction

    function automatic logic [HOLD_W-1:0] type_hold(input logic [TYPE_W-1:0] kind);
        logic [HOLD_W-1:0] h;
        unique case (kind)
            3'd0, 3'd1, 3'd2: h = 10'd250;
            3'd3, 3'd4, 3'd7: h = 10'd500;
            default:          h = 10'd750;
        endcase
        return h;
    endfunction

    function automatic logic [AGE_W-1:0] type_age(input logic [TYPE_W-1:0] kind);
        logic [AGE_W-1:0] a;
        unique case (kind)
            3'd3, 3'd4, 3'd5: a = 13'd8000;
            3'd7:             a = 13'd4000;
            default:          a = 13'd5000;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// File: rtl/ptea_if.sv
`default_nettype none
interface ptea_req_if import ptea_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          operation;
    logic [TYPE_W-1:0]   request_type;
    logic [PORT_DW-1:0]  request_payload;
    logic [OFF_W-1:0]    entry_offset;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, operation, request_type, request_payload, entry_offset,
                    now_ms, input ready);
    modport sink   (input valid, operation, request_type, request_payload, entry_offset,
                    now_ms, output ready);
endinterface

interface ptea_rsp_if import ptea_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [OFF_W-1:0]    chosen_offset;
    logic [TYPE_W-1:0]   chosen_type;
    logic [PORT_DW-1:0]  chosen_payload;
    logic [CNT_W-1:0]    queue_count;

    modport source (output valid, status, chosen_offset, chosen_type, chosen_payload,
                    queue_count, input ready);
    modport sink   (input valid, status, chosen_offset, chosen_type, chosen_payload,
                    queue_count, output ready);
endinterface
`default_nettype wire

// File: rtl/priority_throttle_expiry_arbiter_core.sv
// enqueue, dispatch and no-op go from accept through the execute and done states to the result beat
// select on a non-empty queue also passes through the scan state: the queue rotates once through the row of cells
// one request in flight; ready rises again in the cycle after the result is loaded
// the output register holds a finished result while the next request is accepted
// synchronous active-low reset empties the queue and clears every dispatch time
`default_nettype none
module priority_throttle_expiry_arbiter_core import ptea_pkg::*; #(
    parameter int QUEUE_DEPTH   = 8,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ptea_req_if.sink   i_req,
    ptea_rsp_if.source o_rsp
);

    localparam int N  = QUEUE_DEPTH;
    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);
    // stored payload never exceeds the port width
    localparam int DW = (PAYLOAD_WIDTH < PORT_DW) ? PAYLOAD_WIDTH : PORT_DW;

    t_cmd              w_cmd;
    logic [IW-1:0]     w_pos;
    logic [TYPE_W-1:0] w_new_kind;
    logic [TIME_W-1:0] w_new_time;
    logic [DW-1:0]     w_new_data;
    logic [IW-1:0]     w_pick_idx;
    logic [TYPE_W-1:0] w_pick_kind;
    logic [DW-1:0]     w_pick_data;

    // entry contents, cell 0 is the head of the queue
    logic [TYPE_W-1:0] w_kind [N];
    logic [TIME_W-1:0] w_time [N];
    logic [DW-1:0]     w_data [N];

    ptea_ctrl #(
        .N  (N),
        .IW (IW),
        .CW (CW),
        .DW (DW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_cmd       (w_cmd),
        .o_pos       (w_pos),
        .o_new_kind  (w_new_kind),
        .o_new_time  (w_new_time),
        .o_new_data  (w_new_data),
        .o_pick_idx  (w_pick_idx),
        .i_pick_kind (w_pick_kind),
        .i_pick_data (w_pick_data),
        .i_head_kind (w_kind[0]),
        .i_head_time (w_time[0]),
        .i_head_data (w_data[0])
    );

    // row of cells, each hands its entry to the cell in front of it
    for (genvar g = 0; g < N; g++) begin : g_cell
        localparam int NX = (g + 1 < N) ? g + 1 : g;
        ptea_cell #(
            .IDX (g),
            .IW  (IW),
            .DW  (DW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_pos       (w_pos),
            .i_new_kind  (w_new_kind),
            .i_new_time  (w_new_time),
            .i_new_data  (w_new_data),
            .i_nxt_kind  (w_kind[NX]),
            .i_nxt_time  (w_time[NX]),
            .i_nxt_data  (w_data[NX]),
            .i_head_kind (w_kind[0]),
            .i_head_time (w_time[0]),
            .i_head_data (w_data[0]),
            .o_kind      (w_kind[g]),
            .o_time      (w_time[g]),
            .o_data      (w_data[g])
        );
    end

    // dispatch reads the entry at the requested offset
    assign w_pick_kind = w_kind[w_pick_idx];
    assign w_pick_data = w_data[w_pick_idx];

endmodule
`default_nettype wire

// File: rtl/ptea_cell.sv
`default_nettype none
module ptea_cell import ptea_pkg::*; #(
    parameter int IDX = 0,
    parameter int IW  = 3,
    parameter int DW  = 32
) (
    input  wire logic              i_clk,
    input  wire t_cmd              i_cmd,
    input  wire logic [IW-1:0]     i_pos,
    input  wire logic [TYPE_W-1:0] i_new_kind,
    input  wire logic [TIME_W-1:0] i_new_time,
    input  wire logic [DW-1:0]     i_new_data,
    input  wire logic [TYPE_W-1:0] i_nxt_kind,
    input  wire logic [TIME_W-1:0] i_nxt_time,
    input  wire logic [DW-1:0]     i_nxt_data,
    input  wire logic [TYPE_W-1:0] i_head_kind,
    input  wire logic [TIME_W-1:0] i_head_time,
    input  wire logic [DW-1:0]     i_head_data,
    output logic      [TYPE_W-1:0] o_kind,
    output logic      [TIME_W-1:0] o_time,
    output logic      [DW-1:0]     o_data
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [TYPE_W-1:0] r_kind;
    logic [TIME_W-1:0] r_time;
    logic [DW-1:0]     r_data;

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_LOAD: begin
                if (MY_IDX == i_pos) begin
                    r_kind <= i_new_kind;
                    r_time <= i_new_time;
                    r_data <= i_new_data;
                end
            end
            // shift toward the head, the head entry re-enters at the tail
            CMD_ROT: begin
                if (MY_IDX < i_pos) begin
                    r_kind <= i_nxt_kind;
                    r_time <= i_nxt_time;
                    r_data <= i_nxt_data;
                end else if (MY_IDX == i_pos) begin
                    r_kind <= i_head_kind;
                    r_time <= i_head_time;
                    r_data <= i_head_data;
                end
            end
            // close the gap left at the removed position
            CMD_DEL: begin
                if (MY_IDX >= i_pos) begin
                    r_kind <= i_nxt_kind;
                    r_time <= i_nxt_time;
                    r_data <= i_nxt_data;
                end
            end
            CMD_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    assign o_kind = r_kind;
    assign o_time = r_time;
    assign o_data = r_data;

endmodule
`default_nettype wire

// File: rtl/ptea_ctrl.sv
`default_nettype none
module ptea_ctrl import ptea_pkg::*; #(
    parameter int N  = 8,
    parameter int IW = 3,
    parameter int CW = 4,
    parameter int DW = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    ptea_req_if.sink               i_req,
    ptea_rsp_if.source             o_rsp,
    output t_cmd                   o_cmd,
    output logic      [IW-1:0]     o_pos,
    output logic      [TYPE_W-1:0] o_new_kind,
    output logic      [TIME_W-1:0] o_new_time,
    output logic      [DW-1:0]     o_new_data,
    output logic      [IW-1:0]     o_pick_idx,
    input  wire logic [TYPE_W-1:0] i_pick_kind,
    input  wire logic [DW-1:0]     i_pick_data,
    input  wire logic [TYPE_W-1:0] i_head_kind,
    input  wire logic [TIME_W-1:0] i_head_time,
    input  wire logic [DW-1:0]     i_head_data
);

    localparam int CMPW = (CW > OFF_W) ? CW : OFF_W;

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [TYPE_W-1:0]   r_type, n_type;
    logic [DW-1:0]       r_data, n_data;
    logic [OFF_W-1:0]    r_off, n_off;
    logic [TIME_W-1:0]   r_now, n_now;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [CW-1:0]       r_left, n_left;
    logic [IW-1:0]       r_kept, n_kept;
    logic                r_found, n_found;
    logic [IW-1:0]       r_b_off, n_b_off;
    logic [TYPE_W-1:0]   r_b_kind, n_b_kind;
    logic [DW-1:0]       r_b_data, n_b_data;
    logic [TIME_W-1:0]   r_b_time, n_b_time;
    logic [PRIO_W-1:0]   r_b_prio, n_b_prio;
    logic [TIME_W-1:0]   r_last [TYPE_COUNT];
    logic [TIME_W-1:0]   n_last [TYPE_COUNT];
    t_status             r_res_st, n_res_st;
    logic [OFF_W-1:0]    r_res_off, n_res_off;
    logic [TYPE_W-1:0]   r_res_type, n_res_type;
    logic [DW-1:0]       r_res_data, n_res_data;
    logic [CW-1:0]       r_res_cnt, n_res_cnt;

    logic                r_o_valid;
    t_status             r_o_st;
    logic [OFF_W-1:0]    r_o_off;
    logic [TYPE_W-1:0]   r_o_type;
    logic [DW-1:0]       r_o_data;
    logic [CW-1:0]       r_o_cnt;

    logic [CMPW-1:0]     w_off_c, w_cnt_c;
    logic [TIME_W-1:0]   w_age, w_last, w_since;
    logic                w_expired, w_throttled, w_better;
    logic [PRIO_W-1:0]   w_prio;
    logic                w_out_load;

    // per-entry scoring on the head cell
    assign w_age       = r_now - i_head_time;
    assign w_expired   = w_age > TIME_W'(type_age(i_head_kind));
    assign w_last      = r_last[i_head_kind];
    assign w_since     = r_now - w_last;
    assign w_throttled = (w_last != '0) && (w_since < TIME_W'(type_hold(i_head_kind)));
    assign w_prio      = type_prio(i_head_kind);
    assign w_better    = !r_found || (w_prio > r_b_prio) ||
                         ((w_prio == r_b_prio) && (i_head_time < r_b_time));

    assign w_off_c     = CMPW'(r_off);
    assign w_cnt_c     = CMPW'(r_cnt);
    assign o_pick_idx  = w_off_c[IW-1:0];
    assign o_new_kind  = r_type;
    assign o_new_time  = r_now;
    assign o_new_data  = r_data;
    assign w_out_load  = (r_state == S_DONE) && (!r_o_valid || o_rsp.ready);

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_type     = r_type;
        n_data     = r_data;
        n_off      = r_off;
        n_now      = r_now;
        n_cnt      = r_cnt;
        n_left     = r_left;
        n_kept     = r_kept;
        n_found    = r_found;
        n_b_off    = r_b_off;
        n_b_kind   = r_b_kind;
        n_b_data   = r_b_data;
        n_b_time   = r_b_time;
        n_b_prio   = r_b_prio;
        n_last     = r_last;
        n_res_st   = r_res_st;
        n_res_off  = r_res_off;
        n_res_type = r_res_type;
        n_res_data = r_res_data;
        n_res_cnt  = r_res_cnt;
        o_cmd      = CMD_HOLD;
        o_pos      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = t_op'(i_req.operation);
                    n_type  = i_req.request_type;
                    n_data  = i_req.request_payload[DW-1:0];
                    n_off   = i_req.entry_offset;
                    n_now   = i_req.now_ms;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_st   = ST_OK;
                n_res_off  = '0;
                n_res_type = '0;
                n_res_data = '0;
                n_res_cnt  = r_cnt;
                n_state    = S_DONE;
                unique case (r_op)
                    OP_ENQ: begin
                        if (r_cnt == CW'(N)) begin
                            n_res_st = ST_FULL;
                        end else begin
                            o_cmd     = CMD_LOAD;
                            o_pos     = r_cnt[IW-1:0];
                            n_cnt     = r_cnt + 1'b1;
                            n_res_cnt = n_cnt;
                        end
                    end
                    OP_SEL: begin
                        n_left  = r_cnt;
                        n_kept  = '0;
                        n_found = 1'b0;
                        if (r_cnt == '0) begin
                            n_res_st = ST_NONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    OP_DISP: begin
                        if (w_off_c >= w_cnt_c) begin
                            n_res_st = ST_EMPTY;
                        end else begin
                            o_cmd               = CMD_DEL;
                            o_pos               = w_off_c[IW-1:0];
                            n_last[i_pick_kind] = r_now;
                            n_cnt               = r_cnt - 1'b1;
                            n_res_cnt           = n_cnt;
                            n_res_off           = r_off;
                            n_res_type          = i_pick_kind;
                            n_res_data          = i_pick_data;
                        end
                    end
                    OP_NOP: begin
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                // the head leaves and re-enters at the tail unless it has expired
                o_cmd  = CMD_ROT;
                o_pos  = IW'(r_cnt - 1'b1);
                n_left = r_left - 1'b1;
                if (w_expired) begin
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_kept = r_kept + 1'b1;
                    if (!w_throttled && w_better) begin
                        n_found  = 1'b1;
                        n_b_off  = r_kept;
                        n_b_kind = i_head_kind;
                        n_b_data = i_head_data;
                        n_b_time = i_head_time;
                        n_b_prio = w_prio;
                    end
                end
                if (r_left == CW'(1)) begin
                    n_state    = S_DONE;
                    n_res_st   = n_found ? ST_OK : ST_NONE;
                    n_res_off  = n_found ? OFF_W'(n_b_off) : '0;
                    n_res_type = n_found ? n_b_kind : '0;
                    n_res_data = n_found ? n_b_data : '0;
                    n_res_cnt  = n_cnt;
                end
            end
            S_DONE: begin
                if (!r_o_valid || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_last  <= '{default: '0};
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_type     <= n_type;
        r_data     <= n_data;
        r_off      <= n_off;
        r_now      <= n_now;
        r_left     <= n_left;
        r_kept     <= n_kept;
        r_found    <= n_found;
        r_b_off    <= n_b_off;
        r_b_kind   <= n_b_kind;
        r_b_data   <= n_b_data;
        r_b_time   <= n_b_time;
        r_b_prio   <= n_b_prio;
        r_res_st   <= n_res_st;
        r_res_off  <= n_res_off;
        r_res_type <= n_res_type;
        r_res_data <= n_res_data;
        r_res_cnt  <= n_res_cnt;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_load) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_st   <= r_res_st;
            r_o_off  <= r_res_off;
            r_o_type <= r_res_type;
            r_o_data <= r_res_data;
            r_o_cnt  <= r_res_cnt;
        end
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_o_valid;
    assign o_rsp.status         = r_o_st;
    assign o_rsp.chosen_offset  = r_o_off;
    assign o_rsp.chosen_type    = r_o_type;
    assign o_rsp.chosen_payload = PORT_DW'(r_o_data);
    assign o_rsp.queue_count    = CNT_W'(r_o_cnt);

endmodule
`default_nettype wire

// File: rtl/ptea_chk.sv
`default_nettype none
module ptea_chk import ptea_pkg::*; #(
    parameter int QUEUE_DEPTH = 8
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_req_valid,
    input wire logic              i_req_ready,
    input wire logic              i_rsp_valid,
    input wire logic              i_rsp_ready,
    input wire logic [1:0]        i_rsp_status,
    input wire logic [OFF_W-1:0]  i_rsp_offset,
    input wire logic [TYPE_W-1:0] i_rsp_type,
    input wire logic [PORT_DW-1:0] i_rsp_payload,
    input wire logic [CNT_W-1:0]  i_rsp_count
);

    // one request at a time: busy right after a beat is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while busy");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid)
        else $error("result beat dropped");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status != ST_OK)) |->
        ((i_rsp_offset == '0) && (i_rsp_type == '0) && (i_rsp_payload == '0)))
        else $error("failed result carries entry fields");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status == ST_FULL)) |-> (i_rsp_count == CNT_W'(QUEUE_DEPTH)))
        else $error("queue full reported below depth");

endmodule

bind priority_throttle_expiry_arbiter_core ptea_chk #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_ptea_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_status  (o_rsp.status),
    .i_rsp_offset  (o_rsp.chosen_offset),
    .i_rsp_type    (o_rsp.chosen_type),
    .i_rsp_payload (o_rsp.chosen_payload),
    .i_rsp_count   (o_rsp.queue_count)
);
`default_nettype wire
